FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/wsra_pkg.sv
package wsra_pkg;

  localparam int WINDOW = 5;

  localparam int RAW_W  = 18;
  localparam int GAIN_W = 10;
  localparam int LIM_W  = 16;
  localparam int DB_W   = 8;
  localparam int W19    = 19;

  localparam int PROD_W = RAW_W + GAIN_W + 1;
  localparam int FRAC_W = 8;
  localparam int QS_W   = PROD_W - FRAC_W;

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = W19 + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(SUM_W);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DBAND = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 10'd443;
  localparam logic [LIM_W-1:0]  LIMIT_RST = 16'd500;
  localparam logic [DB_W-1:0]   DBAND_RST = 8'd5;

  localparam logic signed [W19-1:0] W19_MAX = 19'sh3FFFF;
  localparam logic signed [W19-1:0] W19_MIN = 19'sh40000;

  typedef logic signed [W19-1:0] weight_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_q8;
    logic [LIM_W-1:0]  spike_limit;
    logic [DB_W-1:0]   deadband;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    weight_t weight;
  } qpush_t;

  typedef struct packed {
    logic    valid;
    weight_t weight;
  } qhead_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

FILE: design/wsra_if.sv
interface wsra_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [wsra_pkg::RAW_W-1:0] raw_weight;

  modport source (output valid, output raw_weight, input ready);
  modport sink (input valid, input raw_weight, output ready);
endinterface

interface wsra_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [wsra_pkg::W19-1:0] filtered_weight;
  logic                          spike_rejected;

  modport source (output valid, output filtered_weight, output spike_rejected, input ready);
  modport sink (input valid, input filtered_weight, input spike_rejected, output ready);
endinterface

interface wsra_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wsra_pkg::CFG_IDX_W-1:0]     index;
  logic [wsra_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/wsra_front.sv
module wsra_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [wsra_pkg::GAIN_W-1:0]       gain_q8,
  wsra_in_if.sink                           in_chan,
  input  logic                              q_full,
  output wsra_pkg::qpush_t                  push
);
  import wsra_pkg::*;

  logic                     s1_valid_r, s1_valid_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] adj;
  logic signed [QS_W-1:0]   q;
  weight_t                  sat;
  logic                     push_ok;

  // truncate toward zero, then clip to 19 bits
  always_comb begin
    adj = prod_r + (prod_r[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    q   = adj[PROD_W-1:FRAC_W];
    if (q > QS_W'(W19_MAX)) begin
      sat = W19_MAX;
    end else if (q < QS_W'(W19_MIN)) begin
      sat = W19_MIN;
    end else begin
      sat = q[W19-1:0];
    end
  end

  assign push_ok         = s1_valid_r && !q_full;
  assign in_chan.ready   = !s1_valid_r || push_ok;
  assign push.valid      = push_ok;
  assign push.weight     = sat;

  assign prod_nxt = $signed(in_chan.raw_weight) * $signed({1'b0, gain_q8});

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_chan.valid && in_chan.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ok) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

FILE: design/wsra_queue.sv
module wsra_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  wsra_pkg::qpush_t push,
  input  logic             pop,
  output logic             full,
  output wsra_pkg::qhead_t head
);
  import wsra_pkg::*;

  weight_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full        = (cnt_r == QCNT_W'(QDEPTH));
  assign head.valid  = (cnt_r != '0);
  assign head.weight = mem[rptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push.weight;
    end
  end

endmodule

FILE: design/wsra_back.sv
`include "assert_macros.svh"

module wsra_back (
  input  logic             clk,
  input  logic             rst_n,
  input  wsra_pkg::cfg_t   cfg,
  input  wsra_pkg::qhead_t head,
  output logic             pop,
  wsra_out_if.source       out_chan
);
  import wsra_pkg::*;

  back_state_t state_r, state_nxt;

  weight_t            win_r [WINDOW];
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  weight_t            last_r, last_nxt;
  logic               rej_r, rej_nxt;
  logic [IDX_W-1:0]   sidx_r, sidx_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0]   div_r, div_nxt;
  logic [FILL_W-1:0]  rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  weight_t            out_w_r, out_w_nxt;
  logic               out_rej_r, out_rej_nxt;

  logic signed [W19:0]   diff;
  logic signed [W19+1:0] diff_e;
  logic signed [W19+1:0] lim_e;
  logic                  spike;
  weight_t               w_sel;
  logic                  win_we;
  logic signed [SUM_W-1:0] sum_add;
  logic                  sum_last;
  logic [FILL_W:0]       trial;
  logic                  qbit;
  logic                  slot_free;
  weight_t               q19;
  weight_t               avg;

  assign slot_free = !out_valid_r || out_chan.ready;

  // spike test against the previous result
  always_comb begin
    diff   = {head.weight[W19-1], head.weight} - {last_r[W19-1], last_r};
    diff_e = {diff[W19], diff};
    lim_e  = $signed({{(W19 + 2 - LIM_W){1'b0}}, cfg.spike_limit});
    spike  = (fill_r != '0) && ((diff_e > lim_e) || (diff_e < -lim_e));
    w_sel  = spike ? last_r : head.weight;
  end

  assign sum_add  = sum_r + SUM_W'(win_r[sidx_r]);
  assign sum_last = (FILL_W'(sidx_r) == fill_r - FILL_W'(1));
  assign trial    = {rem_r, div_r[SUM_W-1]} - {1'b0, fill_r};
  assign qbit     = !trial[FILL_W];
  assign q19      = div_r[W19-1:0];
  assign avg      = (q19 < W19'(cfg.deadband)) ? '0 : (neg_r ? -q19 : q19);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          state_nxt = B_SUM;
        end
      end
      B_SUM: begin
        if (sum_last) begin
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (slot_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    win_we        = 1'b0;
    wr_idx_nxt    = wr_idx_r;
    fill_nxt      = fill_r;
    last_nxt      = last_r;
    rej_nxt       = rej_r;
    sidx_nxt      = sidx_r;
    sum_nxt       = sum_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_w_nxt     = out_w_r;
    out_rej_nxt   = out_rej_r;
    case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          win_we     = 1'b1;
          rej_nxt    = spike;
          wr_idx_nxt = (wr_idx_r == IDX_W'(WINDOW - 1)) ? '0 : wr_idx_r + IDX_W'(1);
          fill_nxt   = (fill_r < FILL_W'(WINDOW)) ? fill_r + FILL_W'(1) : fill_r;
          sidx_nxt   = '0;
          sum_nxt    = '0;
        end
      end
      B_SUM: begin
        sum_nxt  = sum_add;
        sidx_nxt = sidx_r + IDX_W'(1);
        if (sum_last) begin
          neg_nxt = sum_add[SUM_W-1];
          div_nxt = sum_add[SUM_W-1] ? -sum_add : sum_add;
          rem_nxt = '0;
          cnt_nxt = CNT_W'(SUM_W - 1);
        end
      end
      B_DIV: begin
        div_nxt = {div_r[SUM_W-2:0], qbit};
        rem_nxt = qbit ? trial[FILL_W-1:0] : {rem_r[FILL_W-2:0], div_r[SUM_W-1]};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      B_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_w_nxt     = avg;
          out_rej_nxt   = rej_r;
          last_nxt      = avg;
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.filtered_weight = out_w_r;
  assign out_chan.spike_rejected  = out_rej_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wr_idx_r    <= '0;
      fill_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      fill_r      <= fill_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rej_r     <= rej_nxt;
    sidx_r    <= sidx_nxt;
    sum_r     <= sum_nxt;
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    neg_r     <= neg_nxt;
    cnt_r     <= cnt_nxt;
    out_w_r   <= out_w_nxt;
    out_rej_r <= out_rej_nxt;
    if (win_we) begin
      win_r[wr_idx_r] <= w_sel;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r <= FILL_W'(WINDOW))
  `ASSERT_ALWAYS(a_idx_bound, clk, rst_n, wr_idx_r < IDX_W'(WINDOW))
  `ASSERT_IMPLIES(a_sum_filled, clk, rst_n, state_r != B_IDLE, fill_r != '0)
  `ASSERT_IMPLIES(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == B_DONE)

endmodule

FILE: design/weight_spike_reject_moving_average_top.sv
// Scale filter with spike rejection and moving average. Each reading is
// scaled by the Q2.8 gain in a one-register front end (the product is
// registered, then truncated and clipped on the way into the queue),
// queued two deep, and handled by a back end that tests it against the
// last result, writes it (the last result instead if it is a spike) into
// the five-entry window, sums the filled entries one per cycle and divides
// by the fill count one quotient bit per cycle in a 22-step divider. While
// the back end works, the front end and queue keep taking readings until
// the queue is full; a finished result waits in the output register while
// the next reading is worked on, which holds in its done state until that
// register is free. Register writes are always accepted and are registered
// before they take effect.
module weight_spike_reject_moving_average_top (
  input  logic      clk,
  input  logic      rst_n,
  wsra_in_if.sink   in_chan,
  wsra_out_if.source out_chan,
  wsra_cfg_if.sink  cfg_chan
);
  import wsra_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  qpush_t push;
  qhead_t head;
  logic   q_full;
  logic   pop;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        CFG_GAIN:  cfg_nxt.gain_q8     = cfg_chan.data[GAIN_W-1:0];
        CFG_LIMIT: cfg_nxt.spike_limit = cfg_chan.data[LIM_W-1:0];
        CFG_DBAND: cfg_nxt.deadband    = cfg_chan.data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_q8     <= GAIN_RST;
      cfg_r.spike_limit <= LIMIT_RST;
      cfg_r.deadband    <= DBAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wsra_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .gain_q8 (cfg_r.gain_q8),
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push)
  );

  wsra_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  wsra_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
